// File: design/msrm_pkg.sv
// shared types and constants of the multipath share ratio monitor
// no dependencies
package msrm_pkg;

    localparam int NSRC     = 4;
    localparam int CFG_IDX_W = 3;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_DATA  = 2'd1;
    localparam logic [1:0] OP_ACK   = 2'd2;
    localparam logic [1:0] OP_OTHER = 2'd3;

    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_NEW    = 2'd1;
    localparam logic [1:0] KIND_RESEND = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_TO    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IGNORE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SEQ_GAP   = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACK,
        ST_CNT,
        ST_WIN,
        ST_DIV,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic accept;
        logic ack_step;
        logic cnt_final;
        logic cnt_step;
        logic win_step;
        logic div_start;
        logic div_step;
        logic fin_step;
    } t_cmd;

    typedef struct packed {
        logic is_tick;
        logic timeout;
        logic data_ok;
        logic recompute;
        logic div_done;
        logic slot_free;
    } t_sts;

endpackage

// File: design/msrm_ctrl.sv
// sequencing state machine of the share ratio monitor
// depends on msrm_pkg
module msrm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  msrm_pkg::t_sts i_sts,
    output msrm_pkg::t_cmd o_cmd
);
    import msrm_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_valid && !i_sts.is_tick) n_state = ST_ACK;
            ST_ACK: if (!i_sts.timeout || i_sts.slot_free) n_state = ST_CNT;
            ST_CNT: begin
                if (i_sts.data_ok) n_state = ST_WIN;
                else if (i_sts.slot_free) n_state = ST_IDLE;
            end
            ST_WIN: begin
                if (i_sts.recompute) n_state = ST_DIV;
                else if (i_sts.slot_free) n_state = ST_IDLE;
            end
            ST_DIV: if (i_sts.div_done) n_state = ST_FIN;
            ST_FIN: if (i_sts.slot_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_stall      = 1'b0;
                o_cmd.accept = i_valid;
            end
            ST_ACK: o_cmd.ack_step = !i_sts.timeout || i_sts.slot_free;
            ST_CNT: begin
                o_cmd.cnt_step  = i_sts.data_ok;
                o_cmd.cnt_final = !i_sts.data_ok && i_sts.slot_free;
            end
            ST_WIN: begin
                o_cmd.div_start = i_sts.recompute;
                o_cmd.win_step  = !i_sts.recompute && i_sts.slot_free;
            end
            ST_DIV: o_cmd.div_step = 1'b1;
            ST_FIN: o_cmd.fin_step = i_sts.slot_free;
            default: o_cmd = '0;
        endcase
    end

    a_div_to_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && i_sts.div_done) |=> (r_state == ST_FIN))
        else $error("divider finish did not reach final step");
    a_tick_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.accept && i_sts.is_tick) |=> (r_state == ST_IDLE))
        else $error("tick left idle");
    a_fin_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.fin_step |=> (r_state == ST_IDLE))
        else $error("final step did not return to idle");

endmodule

// File: design/msrm_dp.sv
// datapath of the share ratio monitor: counters, config, shares, divider, output register
// depends on msrm_pkg
module msrm_dp #(
    parameter int COUNT_BITS = 16,
    parameter int TIME_BITS  = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [msrm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [31:0]                      i_cfg_data,
    input  logic [1:0]                       i_opcode,
    input  logic [2:0]                       i_source,
    input  logic [31:0]                      i_sequence_req,
    input  logic                             i_out_stall,
    input  msrm_pkg::t_cmd                   i_cmd,
    output msrm_pkg::t_sts                   o_sts,
    output logic                             o_out_valid,
    output logic [1:0]                       o_send_kind,
    output logic [7:0]                       o_share_0,
    output logic [7:0]                       o_share_1,
    output logic [7:0]                       o_share_2,
    output logic [7:0]                       o_share_3,
    output logic [31:0]                      o_start_sequence,
    output logic                             o_status,
    output logic                             o_all_acked,
    output logic                             o_last
);
    import msrm_pkg::*;

    localparam int CMP_W = (TIME_BITS > 32) ? TIME_BITS : 32;
    localparam int TOT_W = COUNT_BITS + 2;
    localparam int NUM_W = COUNT_BITS + 8;
    localparam int DEN_W = COUNT_BITS + 9;

    logic [31:0] r_window, r_ack_to, r_gap;
    logic [7:0]  r_frame, r_ignore;
    logic [9:0]  r_thr;

    logic [1:0]  r_op;
    logic [2:0]  r_src;
    logic [31:0] r_seq;

    logic [COUNT_BITS-1:0] r_cnt [NSRC];
    logic [7:0]            r_share [NSRC];
    logic [7:0]            r_prev [NSRC];
    logic [NSRC-1:0]       r_marks;
    logic                  r_acks, r_running, r_init;
    logic [TIME_BITS-1:0]  r_time, r_win_start, r_ack_start;
    logic [31:0]           r_last_seq;

    logic [TOT_W-1:0] r_total;
    logic [NUM_W-1:0] r_rem;
    logic [6:0]       r_quo;
    logic [2:0]       r_step;
    logic [1:0]       r_idx;

    logic             r_o_valid;
    logic [1:0]       r_o_kind;
    logic [7:0]       r_o_share [NSRC];
    logic [31:0]      r_o_seq;
    logic             r_o_status, r_o_all, r_o_last;

    logic [TIME_BITS-1:0] ack_diff, win_diff;
    logic                 timeout, elapsed, slot_free, src_ok, div_bit, send;
    logic [DEN_W-1:0]     den_sh;
    logic [NSRC-1:0]      marks_next;
    logic [TOT_W-1:0]     total_sum;
    logic [9:0]           change;
    logic [31:0]          gap_seq;
    logic [1:0]           idx_next;
    logic [7:0]           new_share;

    assign ack_diff  = r_time - r_ack_start;
    assign win_diff  = r_time - r_win_start;
    assign timeout   = !r_acks && (CMP_W'(ack_diff) > CMP_W'(r_ack_to));
    assign elapsed   = CMP_W'(win_diff) > CMP_W'(r_window);
    assign slot_free = !r_o_valid || !i_out_stall;
    assign src_ok    = (r_src < 3'(NSRC));
    assign gap_seq   = r_last_seq + r_gap;
    assign den_sh    = DEN_W'(r_total) << r_step;
    assign div_bit   = (r_total != '0) && (DEN_W'(r_rem) >= den_sh);
    assign new_share = {r_quo, div_bit};
    assign idx_next  = r_idx + 2'd1;

    always_comb begin
        marks_next = timeout ? '0 : r_marks;
        if (r_op == OP_ACK && src_ok) marks_next[r_src[1:0]] = 1'b1;
        for (int i = 0; i < NSRC; i++) begin
            if (r_share[i] <= r_ignore) marks_next[i] = 1'b1;
        end
    end

    always_comb begin
        total_sum = '0;
        change    = '0;
        for (int i = 0; i < NSRC; i++) begin
            total_sum = total_sum + TOT_W'(r_cnt[i]);
            change    = change + 10'((r_share[i] >= r_prev[i]) ?
                        (r_share[i] - r_prev[i]) : (r_prev[i] - r_share[i]));
        end
    end

    assign send = r_init && (change >= r_thr) && r_acks;

    always_comb begin
        o_sts.is_tick   = (i_opcode == OP_TICK);
        o_sts.timeout   = timeout;
        o_sts.data_ok   = (r_op == OP_DATA) && src_ok;
        o_sts.recompute = r_running && elapsed;
        o_sts.div_done  = (r_idx == 2'(NSRC - 1)) && (r_step == '0);
        o_sts.slot_free = slot_free;
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= 32'd1000;
            r_ack_to <= 32'd250;
            r_frame  <= 8'd100;
            r_thr    <= 10'd10;
            r_ignore <= 8'd5;
            r_gap    <= 32'd100;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WINDOW:    r_window <= i_cfg_data;
                CFG_ACK_TO:    r_ack_to <= i_cfg_data;
                CFG_FRAME:     r_frame  <= i_cfg_data[7:0];
                CFG_THRESHOLD: r_thr    <= i_cfg_data[9:0];
                CFG_IGNORE:    r_ignore <= i_cfg_data[7:0];
                CFG_SEQ_GAP:   r_gap    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // item latch, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op  <= i_opcode;
            r_src <= i_source;
            r_seq <= i_sequence_req;
        end
    end

    // divider working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_total <= total_sum;
            r_idx   <= '0;
            r_step  <= 3'd7;
            r_rem   <= NUM_W'(r_cnt[0]) * NUM_W'(r_frame);
        end else if (i_cmd.div_step) begin
            r_quo  <= new_share[6:0];
            r_step <= r_step - 3'd1;
            if (r_step == '0) begin
                r_idx <= idx_next;
                r_rem <= NUM_W'(r_cnt[idx_next]) * NUM_W'(r_frame);
            end else if (div_bit) begin
                r_rem <= NUM_W'(DEN_W'(r_rem) - den_sh);
            end
        end
    end

    // monitor state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NSRC; i++) begin
                r_cnt[i]   <= '0;
                r_share[i] <= '0;
                r_prev[i]  <= '0;
            end
            r_marks     <= '0;
            r_acks      <= 1'b1;
            r_running   <= 1'b0;
            r_init      <= 1'b0;
            r_time      <= '0;
            r_win_start <= '0;
            r_ack_start <= '0;
            r_last_seq  <= '0;
        end else begin
            if (i_cmd.accept && i_opcode == OP_TICK) r_time <= r_time + TIME_BITS'(1);
            if (i_cmd.ack_step && !r_acks) begin
                if (timeout) r_ack_start <= r_time;
                r_marks <= marks_next;
                r_acks  <= &marks_next;
            end
            if (i_cmd.cnt_step && r_cnt[r_src[1:0]] != '1) begin
                r_cnt[r_src[1:0]] <= r_cnt[r_src[1:0]] + COUNT_BITS'(1);
            end
            if (i_cmd.win_step) begin
                r_last_seq <= r_seq;
                if (!r_running) begin
                    r_win_start <= r_time;
                    r_running   <= 1'b1;
                end
            end
            if (i_cmd.div_start) r_win_start <= r_time;
            if (i_cmd.div_step && r_step == '0) r_share[r_idx] <= new_share;
            if (i_cmd.fin_step) begin
                r_last_seq <= r_seq;
                r_init     <= 1'b1;
                for (int i = 0; i < NSRC; i++) begin
                    r_cnt[i]  <= '0;
                    r_prev[i] <= r_share[i];
                end
                if (send) begin
                    r_acks      <= 1'b0;
                    r_marks     <= '0;
                    r_ack_start <= r_time;
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (slot_free) begin
            r_o_valid <= (i_cmd.ack_step && timeout) || i_cmd.cnt_final ||
                         i_cmd.win_step || i_cmd.fin_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (slot_free) begin
            for (int i = 0; i < NSRC; i++) r_o_share[i] <= r_share[i];
            if (i_cmd.ack_step && timeout) begin
                r_o_kind   <= KIND_RESEND;
                r_o_seq    <= gap_seq;
                r_o_status <= 1'b0;
                r_o_all    <= 1'b0;
                r_o_last   <= 1'b0;
            end else if (i_cmd.cnt_final || i_cmd.win_step) begin
                r_o_kind   <= KIND_NONE;
                r_o_seq    <= '0;
                r_o_status <= i_cmd.cnt_final && (r_op != OP_ACK);
                r_o_all    <= r_acks;
                r_o_last   <= 1'b1;
            end else if (i_cmd.fin_step) begin
                r_o_kind   <= send ? KIND_NEW : KIND_NONE;
                r_o_seq    <= send ? gap_seq : '0;
                r_o_status <= 1'b0;
                r_o_all    <= r_acks && !send;
                r_o_last   <= 1'b1;
            end
        end
    end

    assign o_out_valid      = r_o_valid;
    assign o_send_kind      = r_o_kind;
    assign o_share_0        = r_o_share[0];
    assign o_share_1        = r_o_share[1];
    assign o_share_2        = r_o_share[2];
    assign o_share_3        = r_o_share[3];
    assign o_start_sequence = r_o_seq;
    assign o_status         = r_o_status;
    assign o_all_acked      = r_o_all;
    assign o_last           = r_o_last;

endmodule

// File: design/multipath_share_ratio_monitor.sv
// top level of the multipath share ratio monitor
// depends on msrm_pkg, msrm_ctrl, msrm_dp
//
// One item is handled at a time. A tick is counted in idle; a packet passes through the
// ack and count states, a data packet also the window state, and one that closes a
// measurement window the divide state, where the shared restoring divider works out
// each of the four shares in turn, and the final state. Output stalls hold the sequence.
module multipath_share_ratio_monitor #(
    parameter int COUNT_BITS = 16,
    parameter int TIME_BITS  = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [msrm_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]                    i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [1:0]                     i_opcode,
    input  logic [2:0]                     i_source,
    input  logic [31:0]                    i_sequence_req,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [1:0]                     o_send_kind,
    output logic [7:0]                     o_share_0,
    output logic [7:0]                     o_share_1,
    output logic [7:0]                     o_share_2,
    output logic [7:0]                     o_share_3,
    output logic [31:0]                    o_start_sequence,
    output logic                           o_status,
    output logic                           o_all_acked,
    output logic                           o_last
);
    import msrm_pkg::*;

    t_cmd cmd;
    t_sts sts;

    msrm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    msrm_dp #(
        .COUNT_BITS (COUNT_BITS),
        .TIME_BITS  (TIME_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_opcode         (i_opcode),
        .i_source         (i_source),
        .i_sequence_req   (i_sequence_req),
        .i_out_stall      (i_stall),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .o_out_valid      (o_valid),
        .o_send_kind      (o_send_kind),
        .o_share_0        (o_share_0),
        .o_share_1        (o_share_1),
        .o_share_2        (o_share_2),
        .o_share_3        (o_share_3),
        .o_start_sequence (o_start_sequence),
        .o_status         (o_status),
        .o_all_acked      (o_all_acked),
        .o_last           (o_last)
    );

endmodule

// File: dv/multipath_share_ratio_monitor_tb.sv
// testbench of the multipath share ratio monitor: random and directed packets and ticks,
// results checked against an in-bench predictor of shares, sends and acks
// depends on msrm_pkg and multipath_share_ratio_monitor
`timescale 1ns / 1ps
module multipath_share_ratio_monitor_tb;
    import msrm_pkg::*;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  sh0, sh1, sh2, sh3;
        logic [31:0] start_seq;
        logic        status;
        logic        acked;
        logic        last;
    } t_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [1:0] i_opcode = '0;
    logic [2:0] i_source = '0;
    logic [31:0] i_sequence_req = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic [1:0] o_send_kind;
    logic [7:0] o_share_0, o_share_1, o_share_2, o_share_3;
    logic [31:0] o_start_sequence;
    logic o_status, o_all_acked, o_last;

    multipath_share_ratio_monitor dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predictor state
    logic [31:0] m_window, m_ack_to, m_gap;
    logic [7:0]  m_frame, m_ignore;
    logic [9:0]  m_thresh;
    logic [15:0] m_cnt [4];
    logic [7:0]  m_share [4];
    logic [7:0]  m_prev [4];
    logic        m_mark [4];
    logic        m_complete, m_running, m_init;
    logic [31:0] m_now, m_win_start, m_ack_start, m_last_seq;

    t_res expected_q [$];
    int   errors = 0;
    bit   idle_on = 1'b1;

    function automatic t_res make_res(logic [1:0] k, logic [31:0] s, logic st, logic l);
        t_res r;
        r.kind = k;
        r.sh0 = m_share[0];
        r.sh1 = m_share[1];
        r.sh2 = m_share[2];
        r.sh3 = m_share[3];
        r.start_seq = s;
        r.status = st;
        r.acked = m_complete;
        r.last = l;
        return r;
    endfunction

    function automatic logic [31:0] issue_shares();
        m_complete = 1'b0;
        for (int i = 0; i < 4; i++) m_mark[i] = 1'b0;
        m_ack_start = m_now;
        return m_last_seq + m_gap;
    endfunction

    task automatic predict_item(logic [1:0] op, logic [2:0] src, logic [31:0] seq);
        logic all;
        logic [31:0] total, change, sseq;
        logic [1:0] sent;
        if (op == OP_TICK) begin
            m_now = m_now + 1;
            return;
        end
        if (!m_complete) begin
            all = 1'b1;
            if (m_now - m_ack_start > m_ack_to) begin
                sseq = issue_shares();
                expected_q.push_back(make_res(KIND_RESEND, sseq, 1'b0, 1'b0));
            end
            if (op == OP_ACK && src < 4) m_mark[src] = 1'b1;
            for (int i = 0; i < 4; i++) begin
                if (m_share[i] <= m_ignore) m_mark[i] = 1'b1;
                if (!m_mark[i]) all = 1'b0;
            end
            m_complete = all;
        end
        if (op == OP_ACK) begin
            expected_q.push_back(make_res(KIND_NONE, 0, 1'b0, 1'b1));
            return;
        end
        if (op != OP_DATA || src >= 4) begin
            expected_q.push_back(make_res(KIND_NONE, 0, 1'b1, 1'b1));
            return;
        end
        if (m_cnt[src] != 16'hffff) m_cnt[src]++;
        sent = KIND_NONE;
        sseq = 0;
        if (!m_running) begin
            m_win_start = m_now;
            m_running = 1'b1;
        end else if (m_now - m_win_start > m_window) begin
            m_win_start = m_now;
            total = 0;
            change = 0;
            for (int i = 0; i < 4; i++) total += m_cnt[i];
            for (int i = 0; i < 4; i++) begin
                m_share[i] = total != 0 ? 8'((m_cnt[i] * m_frame) / total) : 8'd0;
                m_cnt[i] = 0;
            end
            if (!m_init) begin
                for (int i = 0; i < 4; i++) m_prev[i] = m_share[i];
                m_init = 1'b1;
            end else begin
                for (int i = 0; i < 4; i++) begin
                    change += m_share[i] >= m_prev[i] ? m_share[i] - m_prev[i]
                                                      : m_prev[i] - m_share[i];
                    m_prev[i] = m_share[i];
                end
                if (change >= m_thresh && m_complete) begin
                    sseq = issue_shares();
                    sent = KIND_NEW;
                end
            end
        end
        m_last_seq = seq;
        expected_q.push_back(make_res(sent, sseq, 1'b0, 1'b1));
    endtask

    task automatic send_item(logic [1:0] op, logic [2:0] src, logic [31:0] seq);
        if (idle_on) begin
            while ($urandom_range(99) < 34) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid <= 1'b1;
        i_opcode <= op;
        i_source <= src;
        i_sequence_req <= seq;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_item(op, src, seq);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            CFG_WINDOW:    m_window = val;
            CFG_ACK_TO:    m_ack_to = val;
            CFG_FRAME:     m_frame = val[7:0];
            CFG_THRESHOLD: m_thresh = val[9:0];
            CFG_IGNORE:    m_ignore = val[7:0];
            CFG_SEQ_GAP:   m_gap = val;
            default: ;
        endcase
    endtask

    task automatic set_all(logic [31:0] w, logic [31:0] a, logic [7:0] f, logic [9:0] t,
                           logic [7:0] ig, logic [31:0] g);
        drain();
        write_reg(CFG_WINDOW, w);
        write_reg(CFG_ACK_TO, a);
        write_reg(CFG_FRAME, {24'd0, f});
        write_reg(CFG_THRESHOLD, {22'd0, t});
        write_reg(CFG_IGNORE, {24'd0, ig});
        write_reg(CFG_SEQ_GAP, g);
        i_cfg_we <= 1'b0;
    endtask

    task automatic test_directed();
        send_item(OP_OTHER, 3'd0, 32'd0);
        send_item(OP_DATA, 3'd7, 32'hffffffff);
        send_item(OP_ACK, 3'd5, 32'd0);
        send_item(OP_DATA, 3'd0, 32'hffffffff);
        send_item(OP_TICK, 3'd0, 32'd0);
        send_item(OP_TICK, 3'd0, 32'd0);
        send_item(OP_DATA, 3'd1, 32'd5);
        send_item(OP_DATA, 3'd0, 32'd6);
        send_item(OP_TICK, 3'd0, 32'd0);
        send_item(OP_DATA, 3'd2, 32'd7);
        send_item(OP_DATA, 3'd3, 32'd8);
        send_item(OP_TICK, 3'd0, 32'd0);
        send_item(OP_TICK, 3'd0, 32'd0);
        send_item(OP_DATA, 3'd0, 32'd9);
        send_item(OP_ACK, 3'd0, 32'd0);
        send_item(OP_TICK, 3'd0, 32'd0);
        send_item(OP_TICK, 3'd0, 32'd0);
        send_item(OP_DATA, 3'd3, 32'd10);
        send_item(OP_ACK, 3'd1, 32'd0);
        send_item(OP_ACK, 3'd2, 32'd0);
        send_item(OP_ACK, 3'd3, 32'd0);
        send_item(OP_OTHER, 3'd4, 32'h80000000);
    endtask

    task automatic test_random(int n, int tick_pct, int src_max);
        int r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (r < tick_pct)
                send_item(OP_TICK, 3'($urandom_range(7)), $urandom);
            else if (r < tick_pct + 45)
                send_item(OP_DATA, 3'($urandom_range(src_max)), $urandom);
            else if (r < tick_pct + 60)
                send_item(OP_ACK, 3'($urandom_range(src_max)), $urandom);
            else
                send_item(OP_OTHER, 3'($urandom_range(7)), $urandom);
        end
    endtask

    task automatic test_pause_for_results();
        test_random(40, 30, 3);
        i_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        test_random(40, 30, 4);
    endtask

    // result checker; also drives random output stalls
    always @(posedge i_clk) begin
        if (i_rst_n && !($urandom_range(99) < 34 && idle_on)) i_stall <= 1'b0;
        else i_stall <= 1'b1;
        if (i_rst_n && o_valid && !i_stall) begin
            t_res got, want;
            got = {o_send_kind, o_share_0, o_share_1, o_share_2, o_share_3,
                   o_start_sequence, o_status, o_all_acked, o_last};
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t unexpected transfer: actual %h", $time, got);
            end else begin
                want = expected_q.pop_front();
                if (got !== want) begin
                    errors++;
                    $display("%0t mismatch: expected %h actual %h", $time, want, got);
                end
            end
        end
    end

    initial begin
        m_window = 1000; m_ack_to = 250; m_frame = 100;
        m_thresh = 10; m_ignore = 5; m_gap = 100;
        for (int i = 0; i < 4; i++) begin
            m_cnt[i] = 0; m_share[i] = 0; m_prev[i] = 0; m_mark[i] = 0;
        end
        m_complete = 1'b1; m_running = 1'b0; m_init = 1'b0;
        m_now = 0; m_win_start = 0; m_ack_start = 0; m_last_seq = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        set_all(1, 2, 8'd100, 10'd0, 8'd5, 32'hffffffff);
        test_directed();
        set_all(3, 5, 8'd255, 10'd2, 8'd0, 32'd7);
        test_random(400, 35, 4);
        idle_on = 1'b0;
        test_random(200, 35, 4);
        idle_on = 1'b1;
        set_all(32'hffffffff, 32'hffffffff, 8'd1, 10'd1020, 8'd255, 32'd0);
        test_random(100, 30, 4);
        set_all(0, 0, 8'd0, 10'd0, 8'd0, 32'h12345678);
        test_random(100, 30, 4);
        set_all(2, 4, 8'd37, 10'd1, 8'd3, 32'h80000000);
        test_pause_for_results();
        test_random(600, 40, 3);
        drain();
        if (errors == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #4000000;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
